// File: hw/rtl/sdcsd_pkg.sv
// ============================================================================
// sdcsd_pkg
// Types and constants shared by the CSD register decode pipeline.
// ============================================================================
package sdcsd_pkg;

    // request: the 128-bit CSD register as two halves, byte 0 at the top
    typedef struct packed {
        logic [63:0] csd_upper;
        logic [63:0] csd_lower;
    } t_csd_in;

    // result: decoded fields
    typedef struct packed {
        logic [1:0]  structure_version;
        logic [7:0]  access_time;
        logic [7:0]  access_clocks;
        logic [7:0]  transfer_speed;
        logic [11:0] command_classes;
        logic [3:0]  read_block_len;
        logic [21:0] device_size;
        logic [2:0]  size_multiplier;
        logic [21:0] capacity;
        logic [3:0]  write_block_len;
        logic [1:0]  partial_support;
        logic [8:0]  flag_bits;
    } t_csd_out;

    // structure versions; any nonzero one uses the high-capacity rule
    localparam logic [1:0] VER_LEGACY   = 2'd0;
    localparam logic [1:0] VER_HC       = 2'd1;
    localparam logic [1:0] VER_UC       = 2'd2;
    localparam logic [1:0] VER_RESERVED = 2'd3;

    localparam int unsigned CSD_BYTES  = 16;
    localparam int unsigned SIZE_W     = 22;
    localparam int unsigned CAP_W      = 22;

    // high capacity: (x << 19) / 1e6 == (x << 13) / 15625
    localparam int unsigned HC_PRE_SHIFT = 13;
    localparam int unsigned CAP_DIV_W    = 14;
    localparam logic [CAP_DIV_W-1:0] CAP_DIV = 14'd15625;
    // floor(2^45 / 15625), estimate is low by at most one
    localparam int unsigned RECIP_SHIFT  = 32;
    localparam logic [31:0] CAP_RECIP    = 32'd2251799813;

    // version 0: (x << (mult + 2 + rbl)) >> 20
    localparam int unsigned LEG_X_W      = 13;
    localparam int unsigned LEG_SHIFT_W  = 5;
    localparam int unsigned MIB_SHIFT    = 20;
    localparam int unsigned LEG_WIDE_W   = LEG_X_W + 24;
    localparam int unsigned LEG_CAP_W    = LEG_WIDE_W - MIB_SHIFT;

endpackage

// File: hw/rtl/sdcsd_decode.sv
// ============================================================================
// sdcsd_decode
// First pipeline stage: splits the CSD register into its fields.
// ============================================================================
module sdcsd_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sdcsd_pkg::t_csd_in i_csd,
    output logic               o_valid,
    output logic               o_hc,
    output sdcsd_pkg::t_csd_out o_fields
);

    logic [127:0] w_word;
    logic [7:0]   w_b [sdcsd_pkg::CSD_BYTES];
    logic         w_hc;
    sdcsd_pkg::t_csd_out n_fields;
    logic         r_valid;
    logic         r_hc;
    sdcsd_pkg::t_csd_out r_fields;

    assign w_word = {i_csd.csd_upper, i_csd.csd_lower};

    always_comb begin
        for (int i = 0; i < sdcsd_pkg::CSD_BYTES; i++) begin
            w_b[i] = w_word[127 - 8 * i -: 8];
        end
    end

    assign w_hc = (w_b[0][7:6] != sdcsd_pkg::VER_LEGACY);

    always_comb begin
        n_fields                   = '0;
        n_fields.structure_version = w_b[0][7:6];
        n_fields.access_time       = w_b[1];
        n_fields.access_clocks     = w_b[2];
        n_fields.transfer_speed    = w_b[3];
        n_fields.command_classes   = {w_b[4], w_b[5][7:4]};
        n_fields.read_block_len    = w_b[5][3:0];
        if (w_hc) begin
            n_fields.device_size     = {w_b[7][5:0], w_b[8], w_b[9]};
            n_fields.size_multiplier = 3'd0;
        end else begin
            n_fields.device_size     = {10'd0, w_b[6][1:0], w_b[7], w_b[8][7:6]};
            n_fields.size_multiplier = {w_b[9][1:0], w_b[10][7]};
        end
        n_fields.write_block_len   = {w_b[12][1:0], w_b[13][7:6]};
        n_fields.partial_support   = {w_b[13][5], w_b[6][7]};
        n_fields.flag_bits         = {w_b[14][4], w_b[14][5], w_b[14][6], w_b[14][7],
                                      w_b[12][7], w_b[10][6], w_b[6][4], w_b[6][6],
                                      w_b[6][5]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hc     <= w_hc;
        r_fields <= n_fields;
    end

    assign o_valid  = r_valid;
    assign o_hc     = r_hc;
    assign o_fields = r_fields;

endmodule

// File: hw/rtl/sdcsd_capacity.sv
// ============================================================================
// sdcsd_capacity
// Three-stage capacity unit: reciprocal multiply, back-multiply, correction.
// ============================================================================
module sdcsd_capacity (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_hc,
    input  logic [sdcsd_pkg::SIZE_W-1:0]   i_size,
    input  logic [2:0]                     i_mult,
    input  logic [3:0]                     i_rbl,
    output logic                           o_valid,
    output logic [sdcsd_pkg::CAP_W-1:0]    o_capacity
);

    localparam int unsigned X_W    = sdcsd_pkg::SIZE_W + 1;
    localparam int unsigned PROD_W = X_W + 32;
    localparam int unsigned Y_W    = X_W + sdcsd_pkg::HC_PRE_SHIFT;
    localparam int unsigned Q_W    = sdcsd_pkg::CAP_W;
    localparam int unsigned QM_W   = Q_W + sdcsd_pkg::CAP_DIV_W;

    logic [X_W-1:0]                       w_x;
    logic [sdcsd_pkg::LEG_SHIFT_W-1:0]    w_amt;
    logic [sdcsd_pkg::LEG_WIDE_W-1:0]     w_wide;
    logic [Q_W-1:0]                       w_q;
    logic [Y_W-1:0]                       w_rem;

    logic [PROD_W-1:0]                    n_prod;
    logic [sdcsd_pkg::LEG_CAP_W-1:0]      n_leg;
    logic [QM_W-1:0]                      n_qm;
    logic [Q_W-1:0]                       n_cap;

    logic                                 r_v2, r_v3, r_v4;
    logic                                 r_hc2, r_hc3;
    logic [PROD_W-1:0]                    r_prod2;
    logic [X_W-1:0]                       r_x2;
    logic [sdcsd_pkg::LEG_CAP_W-1:0]      r_leg2, r_leg3;
    logic [QM_W-1:0]                      r_qm3;
    logic [Q_W-1:0]                       r_q3;
    logic [Y_W-1:0]                       r_y3;
    logic [Q_W-1:0]                       r_cap4;

    // stage 2: reciprocal product and the version 0 shift
    assign w_x    = {1'b0, i_size} + X_W'(1);
    assign n_prod = PROD_W'(w_x) * PROD_W'(sdcsd_pkg::CAP_RECIP);
    assign w_amt  = sdcsd_pkg::LEG_SHIFT_W'(i_mult) + sdcsd_pkg::LEG_SHIFT_W'(2)
                  + sdcsd_pkg::LEG_SHIFT_W'(i_rbl);
    assign w_wide = sdcsd_pkg::LEG_WIDE_W'(w_x[sdcsd_pkg::LEG_X_W-1:0]) << w_amt;
    assign n_leg  = w_wide[sdcsd_pkg::LEG_WIDE_W-1:sdcsd_pkg::MIB_SHIFT];

    // stage 3: quotient estimate times divisor
    assign w_q  = r_prod2[sdcsd_pkg::RECIP_SHIFT +: Q_W];
    assign n_qm = QM_W'(w_q) * QM_W'(sdcsd_pkg::CAP_DIV);

    // stage 4: estimate may be one low
    assign w_rem = r_y3 - Y_W'(r_qm3);
    always_comb begin
        if (!r_hc3) begin
            n_cap = Q_W'(r_leg3);
        end else if (w_rem >= Y_W'(sdcsd_pkg::CAP_DIV)) begin
            n_cap = r_q3 + Q_W'(1);
        end else begin
            n_cap = r_q3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hc2   <= i_hc;
        r_prod2 <= n_prod;
        r_x2    <= w_x;
        r_leg2  <= n_leg;
        r_hc3   <= r_hc2;
        r_leg3  <= r_leg2;
        r_qm3   <= n_qm;
        r_q3    <= w_q;
        r_y3    <= {r_x2, sdcsd_pkg::HC_PRE_SHIFT'(0)};
        r_cap4  <= n_cap;
    end

    assign o_valid    = r_v4;
    assign o_capacity = r_cap4;

    // reciprocal estimate is never high and at most one low
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_hc3) |-> (r_qm3 <= QM_W'(r_y3)
                             && w_rem < Y_W'(2 * sdcsd_pkg::CAP_DIV)))
        else $error("capacity quotient estimate out of range");

    a_valid_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v4) |-> $past(r_v3))
        else $error("capacity valid skipped a stage");

endmodule

// File: hw/rtl/sd_csd_register_decode_top.sv
// ============================================================================
// sd_csd_register_decode_top
// SD card CSD register decoder: field extraction and card capacity.
// ============================================================================
//  channel   handshake        payload                       direction
//  request   start / busy     i_csd    (sdcsd_pkg::t_csd_in)  in
//  result    o_done           o_result (sdcsd_pkg::t_csd_out) out
//
//  four-stage pipeline: decode, reciprocal multiply, back-multiply, correct
//  one request per cycle; the result strobes as it leaves the correct stage
//  busy is always low, every start is taken
//  the receiver cannot stall; results are shown for exactly one cycle
//  synchronous active-low reset clears the valid bits only
// ============================================================================
module sd_csd_register_decode_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sdcsd_pkg::t_csd_in   i_csd,
    output logic                 o_done,
    output sdcsd_pkg::t_csd_out  o_result
);

    logic                 w_v1;
    logic                 w_hc1;
    sdcsd_pkg::t_csd_out  w_f1;
    logic                 w_cap_valid;
    logic [sdcsd_pkg::CAP_W-1:0] w_cap;
    sdcsd_pkg::t_csd_out  r_f2, r_f3, r_f4;
    sdcsd_pkg::t_csd_out  n_result;

    assign busy = 1'b0;

    sdcsd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_csd    (i_csd),
        .o_valid  (w_v1),
        .o_hc     (w_hc1),
        .o_fields (w_f1)
    );

    sdcsd_capacity u_capacity (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_v1),
        .i_hc       (w_hc1),
        .i_size     (w_f1.device_size),
        .i_mult     (w_f1.size_multiplier),
        .i_rbl      (w_f1.read_block_len),
        .o_valid    (w_cap_valid),
        .o_capacity (w_cap)
    );

    // decoded fields ride alongside the capacity unit
    always_ff @(posedge i_clk) begin
        r_f2 <= w_f1;
        r_f3 <= r_f2;
        r_f4 <= r_f3;
    end

    always_comb begin
        n_result          = r_f4;
        n_result.capacity = w_cap;
    end

    assign o_done   = w_cap_valid;
    assign o_result = n_result;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done == ($past(start, 4) && $past(i_rst_n, 4) && $past(i_rst_n, 3)
                   && $past(i_rst_n, 2) && $past(i_rst_n, 1)))
        else $error("result strobe not four cycles after request");

    a_hc_mult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.structure_version == sdcsd_pkg::VER_LEGACY
                    || o_result.size_multiplier == 3'd0))
        else $error("multiplier nonzero on high-capacity card");

endmodule

// File: verif/sd_csd_register_decode_top_test.sv
`timescale 1ns / 1ps
// ============================================================================
// sd_csd_register_decode_top_test
// Self-checking bench for the CSD register decoder. Directed register
// images cover field extremes, every structure version and each flag bit.
// Random images follow, random gaps or back to back. Every decoded result is
// checked field by field against an in-bench decode of the same image.
// ============================================================================
module sd_csd_register_decode_top_test;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned PIPE_LATENCY  = 4;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned RANDOM_COUNT  = 1200;
    localparam int unsigned REPORT_LIMIT  = 10;

    localparam int unsigned HC_UNIT_SHIFT = 19;
    localparam int unsigned MEGA          = 1000000;
    localparam int unsigned MIB_BITS      = 20;
    localparam int unsigned BASE_SHIFT    = 2;

    // expected decodes of accepted requests, oldest first
    class csd_decode_board;
        sdcsd_pkg::t_csd_out decoded_q[$];
        int unsigned n_requests = 0;
        int unsigned n_results  = 0;
        int unsigned n_errors   = 0;
        int unsigned ver_count[4] = '{0, 0, 0, 0};

        function sdcsd_pkg::t_csd_out predict_decode(sdcsd_pkg::t_csd_in req);
            logic [127:0]        w;
            sdcsd_pkg::t_csd_out d;
            logic [21:0]         csize;
            logic [63:0]         cap_wide;
            logic [5:0]          sh;
            w = req;
            d = '0;
            d.structure_version = w[127:126];
            d.access_time       = w[119:112];
            d.access_clocks     = w[111:104];
            d.transfer_speed    = w[103:96];
            d.command_classes   = w[95:84];
            d.read_block_len    = w[83:80];
            if (w[127:126] != sdcsd_pkg::VER_LEGACY) begin
                csize = w[69:48];
                d.size_multiplier = 3'd0;
                cap_wide = ((64'(csize) + 64'd1) << HC_UNIT_SHIFT) / 64'(MEGA);
            end else begin
                csize = {10'd0, w[73:62]};
                d.size_multiplier = w[49:47];
                sh = 6'(w[49:47]) + 6'(BASE_SHIFT) + 6'(w[83:80]);
                cap_wide = ((64'(csize) + 64'd1) << sh) >> MIB_BITS;
            end
            d.device_size     = csize;
            d.capacity        = cap_wide[21:0];
            d.write_block_len = w[25:22];
            d.partial_support = {w[21], w[79]};
            d.flag_bits       = {w[12], w[13], w[14], w[15], w[31], w[46],
                                 w[76], w[78], w[77]};
            return d;
        endfunction

        function void note_request(sdcsd_pkg::t_csd_in req);
            decoded_q.push_back(predict_decode(req));
            ver_count[req.csd_upper[63:62]]++;
            n_requests++;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                n_errors++;
                if (n_errors <= REPORT_LIMIT)
                    $display("mismatch result %0d %s: expected %0h got %0h",
                             n_results, name, want, got);
            end
        endfunction

        function void check_result(sdcsd_pkg::t_csd_out got);
            sdcsd_pkg::t_csd_out want;
            if (decoded_q.size() == 0) begin
                n_errors++;
                if (n_errors <= REPORT_LIMIT)
                    $display("mismatch: result %0h with no request pending", got);
                return;
            end
            want = decoded_q.pop_front();
            compare_field("structure_version", 64'(want.structure_version),
                          64'(got.structure_version));
            compare_field("access_time", 64'(want.access_time), 64'(got.access_time));
            compare_field("access_clocks", 64'(want.access_clocks),
                          64'(got.access_clocks));
            compare_field("transfer_speed", 64'(want.transfer_speed),
                          64'(got.transfer_speed));
            compare_field("command_classes", 64'(want.command_classes),
                          64'(got.command_classes));
            compare_field("read_block_len", 64'(want.read_block_len),
                          64'(got.read_block_len));
            compare_field("device_size", 64'(want.device_size), 64'(got.device_size));
            compare_field("size_multiplier", 64'(want.size_multiplier),
                          64'(got.size_multiplier));
            compare_field("capacity", 64'(want.capacity), 64'(got.capacity));
            compare_field("write_block_len", 64'(want.write_block_len),
                          64'(got.write_block_len));
            compare_field("partial_support", 64'(want.partial_support),
                          64'(got.partial_support));
            compare_field("flag_bits", 64'(want.flag_bits), 64'(got.flag_bits));
            n_results++;
        endfunction

        function int unsigned pending();
            return decoded_q.size();
        endfunction
    endclass

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    sdcsd_pkg::t_csd_in  i_csd   = '0;
    logic                o_done;
    sdcsd_pkg::t_csd_out o_result;

    csd_decode_board board;
    int unsigned     quiet_cycles = 0;

    sd_csd_register_decode_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_csd    (i_csd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // acceptance and result sampling on the same edge, pre-update values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                board.check_result(o_result);
            if (start && !busy)
                board.note_request(i_csd);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no request or result for %0d cycles", quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [127:0] noise128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // overwrite version, size, multiplier and read block length in an image
    function automatic sdcsd_pkg::t_csd_in shape_csd(logic [127:0] base,
                                                     logic [1:0] ver,
                                                     logic [21:0] csize,
                                                     logic [2:0] mult,
                                                     logic [3:0] rbl);
        logic [127:0] w;
        w = base;
        w[127:126] = ver;
        w[83:80]   = rbl;
        w[49:47]   = mult;
        if (ver == sdcsd_pkg::VER_LEGACY)
            w[73:62] = csize[11:0];
        else
            w[69:48] = csize;
        return sdcsd_pkg::t_csd_in'(w);
    endfunction

    function automatic sdcsd_pkg::t_csd_in random_csd();
        logic [21:0] csize;
        logic [3:0]  rbl;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return sdcsd_pkg::t_csd_in'(noise128());
        case ($urandom_range(0, 2))
            0: csize = '0;
            1: csize = '1;
            default: csize = 22'($urandom);
        endcase
        case ($urandom_range(0, 2))
            0: rbl = 4'd0;
            1: rbl = 4'hf;
            default: rbl = 4'($urandom_range(9, 11));
        endcase
        return shape_csd(noise128(), 2'($urandom), csize, 3'($urandom), rbl);
    endfunction

    task automatic send_csd(input sdcsd_pkg::t_csd_in req, input int unsigned gap);
        start <= 1'b1;
        i_csd <= req;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            i_csd <= sdcsd_pkg::t_csd_in'(noise128());
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one edge first so the last request has been noted
    task automatic wait_drained();
        @(posedge i_clk);
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(input int unsigned count, input bit no_gaps);
        for (int unsigned k = 0; k < count; k++)
            send_csd(random_csd(), no_gaps ? 0 : pick_gap());
    endtask

    initial begin
        int unsigned  flag_pos[11];
        logic [127:0] w;
        board = new;
        // partial-access and single-bit flag positions in the register
        flag_pos = '{79, 78, 77, 76, 46, 31, 21, 15, 14, 13, 12};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_csd(sdcsd_pkg::t_csd_in'(128'd0), pick_gap());
        send_csd(sdcsd_pkg::t_csd_in'({128{1'b1}}), pick_gap());
        // largest and smallest legacy capacity
        send_csd(shape_csd(noise128(), sdcsd_pkg::VER_LEGACY, '1, 3'd7, 4'hf), pick_gap());
        send_csd(shape_csd('0, sdcsd_pkg::VER_LEGACY, '0, 3'd0, 4'd0), pick_gap());
        send_csd(shape_csd(noise128(), sdcsd_pkg::VER_LEGACY, 22'hfff, 3'd7, 4'd9),
                 pick_gap());
        // high capacity at both ends; multiplier bits set must read back zero
        send_csd(shape_csd('0, sdcsd_pkg::VER_HC, '0, 3'd0, 4'd9), pick_gap());
        send_csd(shape_csd(noise128(), sdcsd_pkg::VER_HC, '1, 3'd7, 4'd9), pick_gap());
        send_csd(shape_csd(noise128(), sdcsd_pkg::VER_UC, 22'($urandom), 3'd5, 4'd9),
                 pick_gap());
        // reserved version follows the high-capacity rule
        send_csd(shape_csd(noise128(), sdcsd_pkg::VER_RESERVED, '1, 3'd7, 4'hf),
                 pick_gap());
        send_csd(shape_csd('1, sdcsd_pkg::VER_RESERVED, 22'd1907, 3'd0, 4'd0),
                 pick_gap());
        send_csd(sdcsd_pkg::t_csd_in'({64{2'b10}}), pick_gap());
        send_csd(sdcsd_pkg::t_csd_in'({64{2'b01}}), pick_gap());
        // only fields that no rule uses, CRC byte among them
        send_csd(sdcsd_pkg::t_csd_in'({64'h0, 64'h3ffc_3fff_7c1f_0fff}), pick_gap());
        foreach (flag_pos[k]) begin
            w = '0;
            w[flag_pos[k]] = 1'b1;
            send_csd(sdcsd_pkg::t_csd_in'(w), 0);
        end

        run_random(RANDOM_COUNT * 2 / 5, 1'b0);
        start <= 1'b0;
        wait_drained();
        run_random(RANDOM_COUNT / 5, 1'b1);
        start <= 1'b0;
        wait_drained();
        run_random(RANDOM_COUNT - RANDOM_COUNT * 3 / 5, 1'b0);
        start <= 1'b0;

        wait_drained();
        repeat (PIPE_LATENCY * 3) @(posedge i_clk);

        $display("covered %0d CSD images and %0d checked decodes, %0d field mismatches",
                 board.n_requests, board.n_results, board.n_errors);
        $display("structure versions 0/1/2/3 seen %0d/%0d/%0d/%0d times",
                 board.ver_count[0], board.ver_count[1], board.ver_count[2],
                 board.ver_count[3]);
        if (board.n_errors == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
